>>> rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths, register indexes and the beat structures that pass along the
// cell chain of the LBA stream detector.
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int ENTRIES   = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LBA_W     = 48;
	localparam int WIN_W     = 24;
	localparam int TTL_W     = 16;
	localparam int LBL_W     = 32;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 24;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
	localparam logic [TTL_W-1:0] TTL_RESET    = TTL_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LBA_WINDOW = CFG_IDX_W'(0),
		CFG_TTL_RELOAD = CFG_IDX_W'(1)
	} cfg_reg_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic             found;
		logic             has_free;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] slot_idx;
		logic [LBA_W-1:0] best_lba;
		logic [LBL_W-1:0] best_label;
	} tok_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic             en;
		logic             found;
		logic             has_free;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] slot_idx;
		logic [LBA_W-1:0] lba;
		logic [TTL_W-1:0] ttl;
		logic [LBL_W-1:0] label;
	} cmt_t;

endpackage

>>> rtl/lsd_cell.sv
// ----------------------------------------------------------------------------
// lsd_cell
// One stream table entry. Compares the searched LBA against its own entry,
// refines the search token from its left neighbour and registers it for the
// right neighbour; applies the match, insert and ageing update on commit.
// ----------------------------------------------------------------------------
module lsd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lsd_pkg::IDX_W-1:0]  cell_idx,
	input  logic [lsd_pkg::LBA_W-1:0]  lba_in,
	input  logic [lsd_pkg::WIN_W-1:0]  window,
	input  lsd_pkg::tok_t              tok_in,
	output lsd_pkg::tok_t              tok_out,
	input  lsd_pkg::cmt_t              cmt
);
	import lsd_pkg::*;

	logic             valid_q;
	logic [LBA_W-1:0] lba_q;
	logic [TTL_W-1:0] ttl_q;
	logic [LBL_W-1:0] label_q;
	tok_t             tok_q;

	logic [LBA_W-1:0] span;
	logic             match;
	tok_t             tok_nxt;

	assign span  = (lba_in > lba_q) ? (lba_in - lba_q) : (lba_q - lba_in);
	assign match = valid_q && (span <= {{(LBA_W-WIN_W){1'b0}}, window});

	always_comb begin
		tok_nxt = tok_in;
		if (match && (!tok_in.found || lba_q < tok_in.best_lba)) begin
			tok_nxt.found      = 1'b1;
			tok_nxt.hit_idx    = cell_idx;
			tok_nxt.best_lba   = lba_q;
			tok_nxt.best_label = label_q;
		end
		if (!valid_q && !tok_in.has_free) begin
			tok_nxt.has_free = 1'b1;
			tok_nxt.slot_idx = cell_idx;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmt.en) begin
			if (cmt.found) begin
				if (cmt.hit_idx == cell_idx) begin
					lba_q <= cmt.lba;
					ttl_q <= cmt.ttl;
				end else if (valid_q && lba_q == cmt.lba) begin
					valid_q <= 1'b0;
				end
			end else if (cmt.has_free && cmt.slot_idx == cell_idx) begin
				valid_q <= 1'b1;
				lba_q   <= cmt.lba;
				ttl_q   <= cmt.ttl;
				label_q <= cmt.label;
			end else if (valid_q) begin
				if (ttl_q <= TTL_W'(1)) begin
					valid_q <= 1'b0;
				end else begin
					ttl_q <= ttl_q - TTL_W'(1);
				end
			end
		end
	end

endmodule

>>> rtl/lba_stream_detector.sv
// ----------------------------------------------------------------------------
// lba_stream_detector
// Sequential stream detector: labels each command LBA with the live stream it
// joins, or opens a new stream with the next sequential label.
// ----------------------------------------------------------------------------
// One LBA is taken per beat and one result beat comes back for each. The
// table is a row of ENTRIES cells; a search token walks the row one cell per
// cycle. A beat passes through the accept step, the token walk along all
// ENTRIES cells and a commit step in which every cell updates at once. The
// next LBA may be taken while the previous result still waits on the output;
// the commit holds only if that result has not been taken yet. Configuration
// writes are always ready; index 0 is the join window, index 1 the TTL
// reload, others are ignored.
// ----------------------------------------------------------------------------
module lba_stream_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsd_pkg::LBA_W-1:0]     lba,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lsd_pkg::LBL_W-1:0]     stream_label,
	output logic                          new_stream,
	output logic                          untracked,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import lsd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [LBA_W-1:0] lba_q;
	logic [WIN_W-1:0] window_q;
	logic [TTL_W-1:0] ttl_reload_q;
	logic [LBL_W-1:0] counter_q;
	logic             out_valid_q;
	logic [LBL_W-1:0] stream_label_q;
	logic             new_stream_q;
	logic             untracked_q;

	tok_t             tok_seed;
	tok_t             tok_chain [ENTRIES+1];
	tok_t             tok_res;
	cmt_t             cmt;
	logic [LBL_W-1:0] next_label;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign stream_label = stream_label_q;
	assign new_stream   = new_stream_q;
	assign untracked    = untracked_q;

	assign out_free   = !out_valid_q || out_ready;
	assign next_label = counter_q + LBL_W'(1);
	assign tok_res    = tok_chain[ENTRIES];

	always_comb begin
		tok_seed = '0;
	end

	assign tok_chain[0] = tok_seed;

	always_comb begin
		cmt          = '0;
		cmt.en       = (state_q == ST_COMMIT) && out_free;
		cmt.found    = tok_res.found;
		cmt.has_free = tok_res.has_free;
		cmt.hit_idx  = tok_res.hit_idx;
		cmt.slot_idx = tok_res.slot_idx;
		cmt.lba      = lba_q;
		cmt.ttl      = ttl_reload_q;
		cmt.label    = next_label;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.lba_in   (lba_q),
			.window   (window_q),
			.tok_in   (tok_chain[g]),
			.tok_out  (tok_chain[g+1]),
			.cmt      (cmt)
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			ttl_reload_q <= TTL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LBA_WINDOW: window_q     <= cfg_data[WIN_W-1:0];
				CFG_TTL_RELOAD: ttl_reload_q <= cfg_data[TTL_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lba_q <= lba;
		end
	end

	// control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_COMMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (tok_res.found) begin
							stream_label_q <= tok_res.best_label;
							new_stream_q   <= 1'b0;
							untracked_q    <= 1'b0;
						end else begin
							counter_q      <= next_label;
							stream_label_q <= next_label;
							new_stream_q   <= 1'b1;
							untracked_q    <= !tok_res.has_free;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_untracked_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(untracked_q && !new_stream_q))
		else $error("untracked result without new stream");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q != LAST_IDX)
		|=> (state_q == ST_SCAN && cnt_q == $past(cnt_q) + IDX_W'(1)))
		else $error("token walk skipped a cell");

	a_commit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && out_valid_q && !out_ready)
		|=> (out_valid_q && $stable(stream_label_q) && state_q == ST_COMMIT))
		else $error("commit overwrote a waiting result");

	a_label_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmt.en && !tok_res.found) |=> (counter_q == $past(next_label)))
		else $error("new stream did not consume a label");

endmodule

>>> dv/tb_lba_stream_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lba_stream_detector
// Self-checking bench for the LBA stream detector.
// A short table of hand-picked LBAs opens the run: first labels, address
// extremes, the window boundary, the smallest-key tie-break with freeing of a
// duplicate key, and filling the table until a stream goes untracked. Random
// phases follow, each under its own window and TTL setting. Most beats follow
// a set of stream heads so that joins, ageing and expiry are reached, and the
// rest open or break streams. A local stream table predicts every result beat
// that carries no typed expectation. Both handshakes idle at random, and
// configuration is only written while the block is idle.
// ----------------------------------------------------------------------------
module tb_lba_stream_detector;

	import lsd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int PHASES       = 7;
	localparam int PHASE_BEATS  = 95;
	localparam int HEADS        = 8;
	localparam int SETTLE_HOLD  = 2 * (ENTRIES + 2) + 4;
	localparam int WDOG_LIMIT   = 4000;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = {CFG_IDX_W{1'b1}};
	localparam logic [LBA_W-1:0]     LBA_MAX        = {LBA_W{1'b1}};

	typedef struct packed {
		logic [LBL_W-1:0] lbl;
		logic             fresh;
		logic             untr;
	} res_t;

	typedef struct {
		logic [LBA_W-1:0] addr;
		bit               typed;
		res_t             res;
	} dir_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [LBA_W-1:0]     lba          = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [LBL_W-1:0]     stream_label;
	logic                 new_stream;
	logic                 untracked;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	// typed expectation travelling with the input beat
	logic                 typed_on     = 1'b0;
	res_t                 typed_res    = '0;

	// predicted stream table
	logic                 trk_valid [ENTRIES];
	logic [LBA_W-1:0]     trk_lba   [ENTRIES];
	logic [TTL_W-1:0]     trk_ttl   [ENTRIES];
	logic [LBL_W-1:0]     trk_label [ENTRIES];
	logic [LBL_W-1:0]     label_ctr  = '0;
	logic [WIN_W-1:0]     join_window = WINDOW_RESET;
	logic [TTL_W-1:0]     ttl_load    = TTL_RESET;

	res_t                 due_results[$];
	int                   err_cnt     = 0;
	int                   idle_cycles = 0;

	// stimulus side
	logic [LBA_W-1:0]     heads [HEADS];
	logic [WIN_W-1:0]     cur_win     = WINDOW_RESET;
	bit                   src_steady  = 1'b0;
	bit                   sink_steady = 1'b0;
	int                   stall_left  = 0;
	dir_row_t             dir_rows[$];

	lba_stream_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.lba          (lba),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.stream_label (stream_label),
		.new_stream   (new_stream),
		.untracked    (untracked),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			trk_valid[i] = 1'b0;
			trk_lba[i]   = '0;
			trk_ttl[i]   = '0;
			trk_label[i] = '0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [LBA_W-1:0] rnd48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[LBA_W-1:0];
	endfunction

	function automatic res_t track_lba(input logic [LBA_W-1:0] addr);
		res_t             r;
		int               hit;
		int               slot;
		logic             found;
		logic             has_free;
		logic [LBA_W-1:0] span;
		found    = 1'b0;
		has_free = 1'b0;
		hit      = 0;
		slot     = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (trk_valid[i]) begin
				span = (addr > trk_lba[i]) ? addr - trk_lba[i] : trk_lba[i] - addr;
				if (span <= LBA_W'(join_window) && (!found || trk_lba[i] < trk_lba[hit])) begin
					hit   = i;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			// keys stay unique: a second entry on the same lba is dropped
			for (int i = 0; i < ENTRIES; i++)
				if (i != hit && trk_valid[i] && trk_lba[i] == addr)
					trk_valid[i] = 1'b0;
			trk_lba[hit] = addr;
			trk_ttl[hit] = ttl_load;
			r = '{trk_label[hit], 1'b0, 1'b0};
			return r;
		end
		label_ctr = label_ctr + 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!has_free && !trk_valid[i]) begin
				slot     = i;
				has_free = 1'b1;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (trk_valid[i]) begin
				if (trk_ttl[i] <= TTL_W'(1))
					trk_valid[i] = 1'b0;
				else
					trk_ttl[i] = trk_ttl[i] - 1'b1;
			end
		end
		if (has_free) begin
			trk_valid[slot] = 1'b1;
			trk_lba[slot]   = addr;
			trk_ttl[slot]   = ttl_load;
			trk_label[slot] = label_ctr;
		end
		r = '{label_ctr, 1'b1, !has_free};
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
	endtask

	// result checking, prediction and register tracking
	always @(posedge clk) begin
		res_t got;
		res_t want;
		bit   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got   = '{stream_label, new_stream, untracked};
				if (due_results.size() == 0) begin
					note_mismatch("result with nothing pending", 64'd0, 64'(got.lbl));
				end else begin
					want = due_results.pop_front();
					if (got.lbl !== want.lbl)
						note_mismatch("stream_label", 64'(want.lbl), 64'(got.lbl));
					if (got.fresh !== want.fresh)
						note_mismatch("new_stream", 64'(want.fresh), 64'(got.fresh));
					if (got.untr !== want.untr)
						note_mismatch("untracked", 64'(want.untr), 64'(got.untr));
				end
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				want  = track_lba(lba);
				if (typed_on)
					want = typed_res;
				due_results.insert(due_results.size(), want);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					CFG_LBA_WINDOW: join_window = cfg_data[WIN_W-1:0];
					CFG_TTL_RELOAD: ttl_load = cfg_data[TTL_W-1:0];
					default: ;
				endcase
			end
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 199) == 0)
				sink_steady <= !sink_steady;
			if (!sink_steady && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	initial begin
		do
			@(posedge clk);
		while (idle_cycles < WDOG_LIMIT);
		$display("lba_stream_detector test failed");
		$finish;
	end

	task automatic add_row(input logic [LBA_W-1:0] addr, input bit typed, input res_t res);
		dir_row_t row;
		row = '{addr, typed, res};
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic push_lba(input logic [LBA_W-1:0] addr, input bit typed, input res_t res);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		lba       <= addr;
		typed_on  <= typed;
		typed_res <= res;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic settle(input int hold);
		in_valid <= 1'b0;
		typed_on <= 1'b0;
		do
			@(posedge clk);
		while (due_results.size() != 0);
		repeat (hold) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dat;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_LBA_WINDOW)
			cur_win = dat[WIN_W-1:0];
	endtask

	function automatic logic [LBA_W-1:0] near_lba(input logic [LBA_W-1:0] base,
			input logic [WIN_W-1:0] w);
		logic [LBA_W-1:0] off;
		case ($urandom_range(0, 5))
			0: off = '0;
			1: off = LBA_W'(w);
			2: off = LBA_W'(w) + 1'b1;
			default: begin
				if (w > 64 && $urandom_range(0, 1) == 0)
					off = LBA_W'($urandom_range(0, 64));
				else
					off = LBA_W'($urandom_range(0, 32'(w) + 2));
			end
		endcase
		return ($urandom_range(0, 1) == 0) ? base + off : base - off;
	endfunction

	function automatic logic [LBA_W-1:0] fresh_head();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LBA_MAX;
			2: return LBA_MAX - LBA_W'($urandom_range(0, 3000));
			3: return LBA_W'($urandom_range(0, 3000));
			default: return rnd48();
		endcase
	endfunction

	task automatic run_random(input int beats);
		int               h;
		int               r;
		logic [LBA_W-1:0] addr;
		for (int n = 0; n < beats; n++) begin
			if ($urandom_range(0, 39) == 0)
				src_steady = !src_steady;
			if ($urandom_range(0, 59) == 0)
				settle(0);
			h = $urandom_range(0, HEADS - 1);
			r = $urandom_range(0, 99);
			if (r < 65) begin
				addr     = near_lba(heads[h], cur_win);
				heads[h] = addr;
			end else if (r < 85) begin
				addr     = fresh_head();
				heads[h] = addr;
			end else begin
				addr = rnd48();
			end
			push_lba(addr, 1'b0, '0);
		end
	endtask

	initial begin
		for (int i = 0; i < HEADS; i++)
			heads[i] = rnd48();

		// directed table
		add_row(LBA_W'(0), 1'b1, '{LBL_W'(1), 1'b1, 1'b0});
		add_row(LBA_MAX, 1'b1, '{LBL_W'(2), 1'b1, 1'b0});
		add_row(LBA_W'(1000), 1'b1, '{LBL_W'(1), 1'b0, 1'b0});
		add_row(LBA_W'(2001), 1'b0, '0);
		add_row(LBA_MAX - LBA_W'(1000), 1'b0, '0);
		add_row(LBA_W'(1500), 1'b0, '0);
		add_row(LBA_W'(2001), 1'b0, '0);
		add_row(LBA_W'(3001), 1'b0, '0);
		for (int k = 1; k < 15; k++)
			add_row(LBA_W'(k) << 43, 1'b0, '0);
		add_row(LBA_W'(15) << 43, 1'b1, '{LBL_W'(18), 1'b1, 1'b1});
		add_row(LBA_W'(3501), 1'b0, '0);
		add_row(LBA_W'(5) << 43, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_lba(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);
		settle(SETTLE_HOLD);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					cfg_write(CFG_UNUSED_LOW, {CFG_DAT_W{1'b1}});
					cfg_write(CFG_LBA_WINDOW, '0);
					cfg_write(CFG_TTL_RELOAD, 24'hFF0001);
				end
				1: begin
					cfg_write(CFG_LBA_WINDOW, {CFG_DAT_W{1'b1}});
					cfg_write(CFG_TTL_RELOAD, 24'h00FFFF);
				end
				2: begin
					cfg_write(CFG_LBA_WINDOW, CFG_DAT_W'($urandom_range(0, 5000)));
					cfg_write(CFG_TTL_RELOAD, '0);
				end
				3: begin
					cfg_write(CFG_LBA_WINDOW, CFG_DAT_W'($urandom_range(0, 2000)));
					cfg_write(CFG_TTL_RELOAD, CFG_DAT_W'($urandom_range(2, 8)));
				end
				4: begin
					cfg_write(CFG_UNUSED_TOP, CFG_DAT_W'($urandom));
					cfg_write(CFG_LBA_WINDOW, CFG_DAT_W'(WINDOW_RESET));
					cfg_write(CFG_TTL_RELOAD, CFG_DAT_W'(TTL_RESET));
				end
				5: begin
					cfg_write(CFG_LBA_WINDOW, CFG_DAT_W'($urandom_range(0, 24'hFFFFFF)));
					cfg_write(CFG_TTL_RELOAD, CFG_DAT_W'($urandom_range(1, 40)));
				end
				default: begin
					cfg_write(CFG_LBA_WINDOW, CFG_DAT_W'($urandom_range(0, 100)));
					cfg_write(CFG_TTL_RELOAD, CFG_DAT_W'($urandom_range(1, 65535)));
				end
			endcase
			run_random(PHASE_BEATS);
			settle(SETTLE_HOLD);
		end

		if (err_cnt == 0 && due_results.size() == 0)
			$display("lba_stream_detector test passed");
		else
			$display("lba_stream_detector test failed");
		$finish;
	end

endmodule
